@@ hdl/ltn_pkg.sv @@
`timescale 1ns / 1ps

package ltn_pkg;

	// Q1.16 constants (16 fraction bits)
	localparam logic [16:0] ONE_Q16       = 17'd65536;
	localparam logic [16:0] HALF_Q16      = 17'd32768;
	localparam logic [15:0] DEFAULT_ALPHA = 16'd6554;

	// register indexes on the write port
	localparam logic [1:0] REG_MAX_DRAFT     = 2'd0;
	localparam logic [1:0] REG_SMOOTHING     = 2'd1;
	localparam logic [1:0] REG_ACTIVE_LAYERS = 2'd2;

	// register reset values
	localparam logic [6:0]  RST_MAX_DRAFT     = 7'd8;
	localparam logic [15:0] RST_SMOOTHING     = 16'd6554;
	localparam logic [6:0]  RST_ACTIVE_LAYERS = 7'd64;

	// one observation or query request
	typedef struct packed {
		logic [5:0]  layer;
		logic [15:0] accepted;
		logic [15:0] total;
	} ltn_item_t;

	// one result
	typedef struct packed {
		logic [6:0]  draft_count;
		logic [16:0] rate;
		logic        layer_valid;
	} ltn_result_t;

endpackage

@@ hdl/ltn_divider.sv @@
`timescale 1ns / 1ps

// Restoring divider for a fraction below one: quotient = floor(num * 2^16 / den),
// valid when num < den. One quotient bit per cycle.
module ltn_divider import ltn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [15:0] quo_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [16:0] shifted;
	logic [17:0] diff;
	logic        ge;

	// one trial subtraction per cycle
	assign shifted = {rem_q, 1'b0};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = ~diff[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= 5'd16;
			end else if (cnt_q != 5'd0) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (cnt_q != 5'd0) begin
			rem_q <= ge ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/ltn_rate_mem.sv @@
`timescale 1ns / 1ps

// Rate table: one write port, one read port with registered data.
module ltn_rate_mem import ltn_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [16:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [16:0]   rdata
);

	logic [16:0] mem_q [DEPTH];
	logic [16:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/per_layer_draft_length_tuner.sv @@
`timescale 1ns / 1ps

// Per-layer draft length tuner.
// Keeps a smoothed Q1.16 acceptance rate per layer and proposes a draft count.
// Request channel: item is taken at a clock edge with start high and busy low.
// Result channel: done is high for one cycle with result; it cannot be held off.
// Config port: cfg_we / cfg_index / cfg_data, written at a clock edge with cfg_we high, no read-back;
// index 0 max_draft, 1 smoothing, 2 active_layers, other indexes are ignored.
// An update request (accepted < total) runs the serial divider, then makes
// three passes through the one shared 17x17 multiplier. A saturated ratio
// (accepted >= total) skips the divider; a query (total zero) makes only the
// draft pass; a rejected layer none. busy stays high meanwhile, so one request
// is in work at a time; a new one may be taken in the done cycle.
// Reset: after arst_n is released the table is cleared to one half, one entry
// a cycle, for every entry with busy high; config writes are taken as ever.
// The receiver cannot stall: each result is shown exactly once.
module per_layer_draft_length_tuner import ltn_pkg::*; #(
	parameter int LAYERS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ltn_item_t   item,
	output logic        done,
	output ltn_result_t result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_LOAD  = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_MUL_A = 9'b000010000,
		S_MUL_B = 9'b000100000,
		S_SUM   = 9'b001000000,
		S_DRAFT = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic        valid_q;
	logic [6:0]  max_draft_q;
	logic [15:0] smoothing_q;
	logic [6:0]  active_layers_q;
	logic [16:0] ratio_q;
	logic [16:0] rate_q;
	logic [33:0] part_q;
	logic [33:0] prod_q;
	logic        done_q;
	ltn_result_t result_q;

	logic        accept;
	logic        layer_ok;
	logic [15:0] alpha;
	logic [6:0]  kmax;
	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [33:0] product;
	logic [34:0] blend_sum;
	logic [16:0] blend_v;
	logic [33:0] draft_sum;
	logic [6:0]  draft_k;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [16:0] mem_wdata;
	logic [16:0] mem_rdata;
	logic        div_done;
	logic [15:0] div_quo;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign layer_ok = ({1'b0, item.layer} < active_layers_q) && (32'(item.layer) < LAYERS);
	assign alpha    = (smoothing_q == 16'd0) ? DEFAULT_ALPHA : smoothing_q;
	assign kmax     = (max_draft_q == 7'd0) ? 7'd1 : max_draft_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_draft_q     <= RST_MAX_DRAFT;
			smoothing_q     <= RST_SMOOTHING;
			active_layers_q <= RST_ACTIVE_LAYERS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_DRAFT:     max_draft_q     <= cfg_data[6:0];
				REG_SMOOTHING:     smoothing_q     <= cfg_data;
				REG_ACTIVE_LAYERS: active_layers_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_MUL_A: begin
				mul_a = {1'b0, alpha};
				mul_b = ratio_q;
			end
			S_MUL_B: begin
				mul_a = ONE_Q16 - {1'b0, alpha};
				mul_b = mem_rdata;
			end
			default: begin
				mul_a = {10'd0, kmax - 7'd1};
				mul_b = rate_q;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	// blend rounding and clip
	assign blend_sum = {1'b0, part_q} + {1'b0, prod_q} + 35'(HALF_Q16);
	assign blend_v   = (blend_sum[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : blend_sum[32:16];

	// draft count rounding and clamp
	assign draft_sum = prod_q + 34'(HALF_Q16);
	assign draft_k   = (7'd1 + draft_sum[22:16] > kmax) ? kmax : 7'd1 + draft_sum[22:16];

	// table write: clearing pass or blended rate
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = blend_v;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = HALF_Q16;
			end
			S_SUM: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	ltn_rate_mem #(
		.DEPTH(LAYERS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(AW'(item.layer)),
		.rdata(mem_rdata)
	);

	ltn_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept && layer_ok && (item.total != 16'd0) && (item.accepted < item.total)),
		.num     (item.accepted),
		.den     (item.total),
		.done    (div_done),
		.quotient(div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(LAYERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (!layer_ok) begin
							state_q <= S_OUT;
						end else if (item.total == 16'd0) begin
							state_q <= S_LOAD;
						end else if (item.accepted >= item.total) begin
							state_q <= S_MUL_A;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_LOAD:  state_q <= S_DRAFT;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_SUM;
				S_SUM:   state_q <= S_DRAFT;
				S_DRAFT: state_q <= S_OUT;
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q  <= AW'(item.layer);
				valid_q <= layer_ok;
				ratio_q <= ONE_Q16;
			end
			S_LOAD:  rate_q  <= mem_rdata;
			S_DIV:   ratio_q <= {1'b0, div_quo};
			S_MUL_A: part_q  <= product;
			S_MUL_B: prod_q  <= product;
			S_SUM:   rate_q  <= blend_v;
			S_DRAFT: prod_q  <= product;
			S_OUT: begin
				if (valid_q) begin
					result_q.draft_count <= draft_k;
					result_q.rate        <= rate_q;
					result_q.layer_valid <= 1'b1;
				end else begin
					result_q.draft_count <= 7'd1;
					result_q.rate        <= '0;
					result_q.layer_valid <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ tb/sv/per_layer_draft_length_tuner_tb.sv @@
`timescale 1ns / 1ps

module per_layer_draft_length_tuner_tb;
	import ltn_pkg::*;

	localparam int N_LAYERS      = 64;
	localparam int RAND_ITEMS    = 1350;
	localparam int RAND_PHASES   = 6;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 400000;
	// index with no register behind it; writes must be ignored
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [15:0] data;
		ltn_item_t   req;
		logic        typed;
		ltn_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	ltn_item_t   item;
	logic        done;
	ltn_result_t result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// mirror of the tuner: rate table and registers
	logic [16:0] layer_rate [N_LAYERS];
	logic [6:0]  max_draft_q;
	logic [15:0] alpha_q;
	logic [6:0]  active_q;

	ltn_result_t owed_results [$];
	stim_row_t   plan [$];
	int          n_bad = 0;
	int          cycles = 0;

	per_layer_draft_length_tuner #(
		.LAYERS(N_LAYERS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// blend the observed ratio into the layer rate, then derive the draft count
	function automatic ltn_result_t tune_layer(ltn_item_t req);
		longint unsigned acc;
		longint unsigned ratio;
		longint unsigned alpha;
		longint unsigned sum;
		longint unsigned kmax;
		longint unsigned k;
		logic [16:0]     r;
		ltn_result_t     res;
		res.draft_count = 7'd1;
		res.rate        = '0;
		res.layer_valid = 1'b0;
		if ({1'b0, req.layer} >= active_q)
			return res;
		if (req.total != 16'd0) begin
			acc   = req.accepted;
			ratio = (acc << 16) / req.total;
			if (ratio > ONE_Q16)
				ratio = ONE_Q16;
			alpha = (alpha_q == 16'd0) ? DEFAULT_ALPHA : alpha_q;
			sum   = alpha * ratio + (ONE_Q16 - alpha) * layer_rate[req.layer] + HALF_Q16;
			sum   = sum >> 16;
			if (sum > ONE_Q16)
				sum = ONE_Q16;
			layer_rate[req.layer] = sum[16:0];
		end
		r    = layer_rate[req.layer];
		kmax = (max_draft_q == 7'd0) ? 1 : max_draft_q;
		k    = 1 + (((kmax - 1) * r + HALF_Q16) >> 16);
		if (k > kmax)
			k = kmax;
		res.draft_count = k[6:0];
		res.rate        = r;
		res.layer_valid = 1'b1;
		return res;
	endfunction

	function automatic void plan_write(logic [1:0] idx, logic [15:0] data);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.data = data;
		plan.push_back(r);
	endfunction

	// typed = 1 when the result is known without working it out
	function automatic void plan_req(int unsigned layer, int unsigned acc, int unsigned tot,
			bit typed, int unsigned cnt, int unsigned rte, bit vld);
		stim_row_t r;
		r                    = '0;
		r.kind               = ROW_REQ;
		r.req.layer          = layer[5:0];
		r.req.accepted       = acc[15:0];
		r.req.total          = tot[15:0];
		r.typed              = typed;
		r.want.draft_count   = cnt[6:0];
		r.want.rate          = rte[16:0];
		r.want.layer_valid   = vld;
		plan.push_back(r);
	endfunction

	// present one request, hold it until taken, and log what it owes
	task automatic send_req(input ltn_item_t req, input bit typed, input ltn_result_t want);
		ltn_result_t model;
		start <= 1'b1;
		item  <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model = tune_layer(req);
		owed_results.push_back(typed ? want : model);
		@(negedge clk);
	endtask

	// quiet the request side and wait for every owed result
	task automatic settle();
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_MAX_DRAFT:     max_draft_q = data[6:0];
			REG_SMOOTHING:     alpha_q     = data;
			REG_ACTIVE_LAYERS: active_q    = data[6:0];
			default:           ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// result check, oldest owed result first
	always @(posedge clk) begin : check_results
		ltn_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (owed_results.size() == 0) begin
				n_bad++;
				$display("%0t unexpected result: expected none, got count=%0d rate=%0d valid=%0d",
					$time, result.draft_count, result.rate, result.layer_valid);
			end else begin
				want = owed_results.pop_front();
				if (result.draft_count !== want.draft_count) begin
					n_bad++;
					$display("%0t draft_count: expected %0d, got %0d",
						$time, want.draft_count, result.draft_count);
				end
				if (result.rate !== want.rate) begin
					n_bad++;
					$display("%0t rate: expected %0d, got %0d", $time, want.rate, result.rate);
				end
				if (result.layer_valid !== want.layer_valid) begin
					n_bad++;
					$display("%0t layer_valid: expected %0d, got %0d",
						$time, want.layer_valid, result.layer_valid);
				end
			end
		end
	end

	// hang guard
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : run
		int unsigned n;
		int unsigned ph;
		int unsigned upper;
		int unsigned pick;
		int unsigned tot;
		int unsigned acc;
		logic [15:0] d_max;
		logic [15:0] d_alpha;
		logic [15:0] d_act;
		bit          quiet;
		ltn_item_t   req;
		stim_row_t   row;

		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_MAX_DRAFT;
		cfg_data  = '0;
		for (int i = 0; i < N_LAYERS; i++)
			layer_rate[i] = HALF_Q16;
		max_draft_q = RST_MAX_DRAFT;
		alpha_q     = RST_SMOOTHING;
		active_q    = RST_ACTIVE_LAYERS;

		// directed: reset state, field extremes, saturation, queries, rejects
		plan_req(0, 0, 0, 1, 5, 32768, 1);
		plan_req(63, 65535, 0, 1, 5, 32768, 1);
		plan_req(1, 65535, 1, 0, 0, 0, 0);
		plan_req(2, 0, 65535, 0, 0, 0, 0);
		plan_req(3, 65535, 65535, 0, 0, 0, 0);
		plan_req(3, 1, 65535, 0, 0, 0, 0);
		plan_req(4, 0, 0, 1, 5, 32768, 1);
		plan_req(6, 32767, 65535, 0, 0, 0, 0);
		plan_req(63, 16'hAAAA, 16'h5555, 0, 0, 0, 0);
		plan_req(42, 16'h5555, 16'hAAAA, 0, 0, 0, 0);
		plan_write(REG_SPARE, 16'hFFFF);
		plan_req(42, 0, 0, 0, 0, 0, 0);
		plan_write(REG_MAX_DRAFT, 16'd64);
		plan_write(REG_SMOOTHING, 16'hFFFF);
		plan_write(REG_ACTIVE_LAYERS, 16'd1);
		plan_req(1, 0, 0, 1, 1, 0, 0);
		plan_req(63, 100, 50, 1, 1, 0, 0);
		plan_req(0, 65535, 1, 0, 0, 0, 0);
		plan_req(0, 0, 0, 0, 0, 0, 0);
		// zero registers: default alpha, single draft, every layer rejected
		plan_write(REG_MAX_DRAFT, 16'd0);
		plan_write(REG_SMOOTHING, 16'd0);
		plan_write(REG_ACTIVE_LAYERS, 16'd0);
		plan_req(0, 0, 0, 1, 1, 0, 0);
		plan_write(REG_ACTIVE_LAYERS, 16'd64);
		plan_req(0, 3, 4, 0, 0, 0, 0);
		plan_write(REG_MAX_DRAFT, 16'd1);
		plan_write(REG_SMOOTHING, 16'd1);
		plan_write(REG_ACTIVE_LAYERS, 16'd63);
		plan_req(63, 5, 5, 1, 1, 0, 0);
		plan_req(62, 1, 2, 0, 0, 0, 0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.data);
			end else begin
				send_req(row.req, row.typed, row.want);
			end
		end

		// random phases, each under its own register setting
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					d_max = 16'd64;
					d_alpha = 16'hFFFF;
					d_act = 16'd64;
				end
				1: begin
					d_max = 16'd1;
					d_alpha = 16'd1;
					d_act = 16'd1;
				end
				3: begin
					d_max = 16'($urandom);
					d_alpha = 16'($urandom);
					d_act = 16'($urandom);
				end
				5: begin
					d_max = RST_MAX_DRAFT;
					d_alpha = RST_SMOOTHING;
					d_act = RST_ACTIVE_LAYERS;
				end
				default: begin
					d_max = 16'($urandom_range(64, 1));
					d_alpha = 16'($urandom_range(65535, 1));
					d_act = 16'($urandom_range(64, 1));
				end
			endcase
			write_reg(REG_MAX_DRAFT, d_max);
			write_reg(REG_SMOOTHING, d_alpha);
			write_reg(REG_ACTIVE_LAYERS, d_act);
			// one whole phase runs back to back
			quiet = (ph == 2);
			for (n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
				if (!quiet && $urandom_range(99) < 13) begin
					start <= 1'b0;
					repeat ($urandom_range(30, 1)) @(negedge clk);
				end
				// mostly layers in use, the rest anywhere
				upper = (active_q > N_LAYERS) ? N_LAYERS : active_q;
				if ($urandom_range(99) < 85 && upper > 0)
					req.layer = 6'($urandom_range(upper - 1, 0));
				else
					req.layer = 6'($urandom_range(N_LAYERS - 1, 0));
				pick = $urandom_range(99);
				if (pick < 15) begin
					// query only
					tot = 0;
					acc = $urandom_range(65535, 0);
				end else if (pick < 55) begin
					// small counts, as a decode step gives
					tot = $urandom_range(16, 1);
					acc = $urandom_range(tot, 0);
				end else if (pick < 65) begin
					// accepted at or above total
					tot = $urandom_range(65535, 1);
					acc = $urandom_range(65535, tot);
				end else begin
					tot = $urandom_range(65535, 0);
					acc = $urandom_range(65535, 0);
				end
				req.accepted = acc[15:0];
				req.total    = tot[15:0];
				send_req(req, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_bad == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ per_layer_draft_length_tuner.f @@
hdl/ltn_pkg.sv
hdl/ltn_divider.sv
hdl/ltn_rate_mem.sv
hdl/per_layer_draft_length_tuner.sv
tb/sv/per_layer_draft_length_tuner_tb.sv
